// ===== hdl/klq_pkg.sv =====
// Shared constants, types and round functions for the KeeLoq pipeline.
`default_nettype none

package klq_pkg;

    // Cipher geometry
    localparam int ROUNDS       = 528;
    localparam int STAGE_ROUNDS = 8;
    localparam int STAGES       = ROUNDS / STAGE_ROUNDS;
    localparam int STAGE_IDX_W  = $clog2(STAGES);
    localparam int STEP_W       = $clog2(STAGE_ROUNDS);
    localparam int BLOCK_W      = 32;
    localparam int KEY_W        = 32;
    localparam int KEY_IDX_W    = $clog2(KEY_W);

    // Nonlinear feedback table and key reset value
    localparam logic [31:0]          NLF_TABLE      = 32'h3A5C742E;
    localparam logic [KEY_W-1:0]     KEY_RESET      = 32'h06660708;
    localparam logic [KEY_IDX_W-1:0] DEC_KEY_OFFSET = KEY_IDX_W'(15);

    // Direction codes
    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    // Control that travels with each block through the stages
    typedef struct packed {
        logic valid;
        op_t  op;
    } stage_ctl_t;

    // One encryption round: shift right, feedback into bit 31
    function automatic logic [BLOCK_W-1:0] enc_round(
        input logic [BLOCK_W-1:0] x,
        input logic               kbit
    );
        logic [4:0] idx;
        logic       fb;
        idx = {x[31], x[26], x[20], x[9], x[1]};
        fb  = x[0] ^ x[16] ^ NLF_TABLE[idx] ^ kbit;
        return {fb, x[BLOCK_W-1:1]};
    endfunction

    // One decryption round: shift left within 32 bits, feedback into bit 0
    function automatic logic [BLOCK_W-1:0] dec_round(
        input logic [BLOCK_W-1:0] x,
        input logic               kbit
    );
        logic [4:0] idx;
        logic       fb;
        idx = {x[30], x[25], x[19], x[8], x[0]};
        fb  = x[31] ^ x[15] ^ NLF_TABLE[idx] ^ kbit;
        return {x[BLOCK_W-2:0], fb};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/klq_stage.sv =====
// One pipeline stage: a group of cipher rounds followed by a register.
`default_nettype none

module klq_stage
    import klq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [STAGE_IDX_W-1:0] stage_idx,
    input  wire logic [KEY_W-1:0]       key_half,
    input  wire stage_ctl_t             ctl_in,
    input  wire logic [BLOCK_W-1:0]     data_in,
    output stage_ctl_t                  ctl_out,
    output logic [BLOCK_W-1:0]          data_out
);

    stage_ctl_t         ctl_reg;
    logic [BLOCK_W-1:0] data_reg;
    logic [BLOCK_W-1:0] data_next;

    // Rounds of this stage; key bit index is the round number mod 32 (encrypt) or (15 - round) mod 32 (decrypt)
    always_comb
    begin
        logic [BLOCK_W-1:0]   x;
        logic [KEY_IDX_W-1:0] kidx;
        x = data_in;
        for (int j = 0; j < STAGE_ROUNDS; j++)
        begin
            kidx = {stage_idx[KEY_IDX_W-STEP_W-1:0], STEP_W'(j)};
            if (ctl_in.op == OP_DECRYPT)
            begin
                x = dec_round(x, key_half[DEC_KEY_OFFSET - kidx]);
            end
            else
            begin
                x = enc_round(x, key_half[kidx]);
            end
        end
        data_next = x;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, op: OP_ENCRYPT};
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Data register, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

// ===== hdl/keeloq_cipher_encrypt_decrypt_core.sv =====
// KeeLoq cipher core: 66-stage round pipeline, 8 rounds per stage.
// Each block is registered in every stage from input transfer to result valid (528 rounds / 8 per stage).
// Throughput: one block per cycle while the output is not stalled; a stalled output freezes the whole pipeline.
// Reset: asynchronous active low; clears all stage valid bits and loads the
// key word with 0x06660708. Key writes are accepted in any cycle.
`default_nettype none

module keeloq_cipher_encrypt_decrypt_core
    import klq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               operation,
    input  wire logic [BLOCK_W-1:0] block_in,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BLOCK_W-1:0]      block_out,
    // key write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [KEY_W-1:0]   key_half
);

    logic [KEY_W-1:0]   key_reg;
    logic               advance;
    stage_ctl_t         ctl   [STAGES+1];
    logic [BLOCK_W-1:0] data  [STAGES+1];

    // Key register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= key_half;
        end
    end

    // Global advance: hold everything while the result waits
    assign advance  = !(ctl[STAGES].valid && out_stall);
    assign in_stall = !advance;

    assign ctl[0]  = '{valid: in_valid, op: op_t'(operation)};
    assign data[0] = block_in;

    // Round pipeline
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        klq_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .stage_idx (STAGE_IDX_W'(s)),
            .key_half  (key_reg),
            .ctl_in    (ctl[s]),
            .data_in   (data[s]),
            .ctl_out   (ctl[s+1]),
            .data_out  (data[s+1])
        );
    end

    // Last stage is the output register
    assign out_valid = ctl[STAGES].valid;
    assign block_out = data[STAGES];

endmodule

`default_nettype wire
